[rtl/jspd_pkg.sv]
package jspd_pkg;

   localparam int JOINTS = 16;
   localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   localparam int REQ_TDATA_W = 200;
   localparam int RSP_TDATA_W = 88;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_TICK = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STEP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RATE  = 2'd2;

   localparam logic [1:0] MODE_TORQUE   = 2'd0;
   localparam logic [1:0] MODE_VELOCITY = 2'd1;
   localparam logic [1:0] MODE_POSITION = 2'd2;

   localparam logic [1:0]  RESET_DRIVE_MODE = MODE_TORQUE;
   localparam logic [15:0] RESET_TIME_STEP  = 16'd66;
   localparam logic [15:0] RESET_STEP_RATE  = 16'd1000;

   localparam logic [73:0] TERM_CAP = 74'd1 << 61;
   localparam logic signed [63:0] DRIVE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] DRIVE_MIN = 64'shFFFF_8000_0000_0000;
   localparam logic [47:0] DRIVE_MAX48 = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] DRIVE_MIN48 = 48'h8000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_TS,
      ST_REF,
      ST_MUL_P,
      ST_MUL_V,
      ST_MUL_DLO,
      ST_MUL_DHI,
      ST_TERM_D,
      ST_DRIVE,
      ST_DONE
   } servo_state_type;

endpackage

[rtl/joint_setpoint_pd_servo.sv]
// Multi-joint PD position servo. A load transaction (tuser 0) stores one joint's gains,
// limits and start position and produces no result. A tick transaction (tuser 1)
// advances the joint's reference by rate times time step over 65536, clamps it and
// returns one drive value, computed by one shared 33 by 32 bit multiplier under a
// sequencer; position mode skips the gain multiplies, and a done tick waits while an
// earlier result is still in the output register. Registers must be written only while
// no tick is in progress (by the user); the block itself does not enforce this.
module joint_setpoint_pd_servo
   import jspd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // joint[3:0], measured_position[35:4], rate[67:36], p_gain[99:68], d_gain[131:100],
   // lower_limit[163:132], upper_limit[195:164], zero fill above.
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // operation[0].
   input  logic [0:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // joint_out[3:0], drive[51:4], reference[83:52], zero fill above.
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // saturated[0].
   output logic [0:0]              rsp_tuser,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   servo_state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic [15:0] time_step_ff;
   logic [15:0] step_rate_ff;

   logic [31:0] ref_pos_ff   [JOINTS];
   logic [31:0] prev_pos_ff  [JOINTS];
   logic [31:0] p_gain_ff    [JOINTS];
   logic [31:0] d_gain_ff    [JOINTS];
   logic [31:0] lower_ff     [JOINTS];
   logic [31:0] upper_ff     [JOINTS];

   logic [JIDX_W-1:0] joint_idx_ff;
   logic [3:0]        joint_ff;
   logic [31:0]       meas_ff;
   logic [31:0]       rate_ff;
   logic [31:0]       ref_rd_ff, prev_rd_ff, p_rd_ff, d_rd_ff, lower_rd_ff, upper_rd_ff;
   logic [31:0]       ref_ff;
   logic              err_neg_ff, diff_neg_ff;
   logic [63:0]       p_term_ff, d_term_ff;
   logic [55:0]       dlo_ff;
   logic [15:0]       vel_hi_ff;
   logic [47:0]       drive_ff;
   logic              sat_ff;
   logic [64:0]       prod_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_joint_ff;
   logic [47:0]       rsp_drive_ff;
   logic [31:0]       rsp_ref_ff;
   logic              rsp_sat_ff;

   logic [3:0]        req_joint;
   logic [31:0]       req_meas, req_rate, req_p, req_d, req_lower, req_upper;
   logic [JIDX_W-1:0] req_idx;
   logic              req_in_range, req_fire, load_fire, tick_fire, done_fire;
   logic              is_velocity, is_position;

   logic [32:0]       mul_a;
   logic [31:0]       mul_b;

   logic [32:0]       rate_mag;
   logic [31:0]       ts_mag;
   logic signed [33:0] ts_term, ref_sum, upper34, lower34, ref_clamp;
   logic [32:0]       err, err_mag, diff, diff_mag;
   logic [56:0]       p_mag;
   logic [73:0]       d_sum;
   logic [73:0]       d_mag;
   logic signed [63:0] total;

   assign req_joint = req_tdata[3:0];
   assign req_meas  = req_tdata[35:4];
   assign req_rate  = req_tdata[67:36];
   assign req_p     = req_tdata[99:68];
   assign req_d     = req_tdata[131:100];
   assign req_lower = req_tdata[163:132];
   assign req_upper = req_tdata[195:164];
   assign req_idx   = JIDX_W'(req_joint);

   assign req_in_range = 32'(req_joint) < 32'(JOINTS);
   assign req_fire     = req_tvalid && req_tready;
   assign load_fire    = req_fire && req_in_range && (req_tuser == OP_LOAD);
   assign tick_fire    = req_fire && req_in_range && (req_tuser == OP_TICK);

   assign is_velocity = (mode_ff == MODE_VELOCITY);
   assign is_position = (mode_ff == MODE_POSITION);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RESET_DRIVE_MODE;
         time_step_ff <= RESET_TIME_STEP;
         step_rate_ff <= RESET_STEP_RATE;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DRIVE_MODE: mode_ff      <= csr_wdata[1:0];
            REG_TIME_STEP:  time_step_ff <= csr_wdata;
            REG_STEP_RATE:  step_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      done_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (tick_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ:    state_in = ST_MUL_TS;
         ST_MUL_TS:  state_in = ST_REF;
         ST_REF:     state_in = is_position ? ST_DONE : ST_MUL_P;
         ST_MUL_P:   state_in = ST_MUL_V;
         ST_MUL_V:   state_in = ST_MUL_DLO;
         ST_MUL_DLO: state_in = ST_MUL_DHI;
         ST_MUL_DHI: state_in = ST_TERM_D;
         ST_TERM_D:  state_in = ST_DRIVE;
         ST_DRIVE:   state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               done_fire = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Shared multiplier: operands chosen by the sequencer, product registered.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_TS: begin
            mul_a = rate_mag;
            mul_b = {16'd0, time_step_ff};
         end
         ST_MUL_P: begin
            mul_a = err_mag;
            mul_b = p_rd_ff;
         end
         ST_MUL_V: begin
            mul_a = diff_mag;
            mul_b = {16'd0, step_rate_ff};
         end
         ST_MUL_DLO: begin
            mul_a = {1'b0, prod_ff[31:0]};
            mul_b = d_rd_ff;
         end
         ST_MUL_DHI: begin
            mul_a = {17'd0, vel_hi_ff};
            mul_b = d_rd_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 65'(mul_a) * 65'(mul_b);
   end

   always_comb begin
      rate_mag = rate_ff[31] ? (33'd0 - {rate_ff[31], rate_ff}) : {1'b0, rate_ff};

      ts_mag    = prod_ff[47:16];
      ts_term   = rate_ff[31] ? (34'sd0 - $signed({2'b00, ts_mag}))
                              : $signed({2'b00, ts_mag});
      ref_sum   = $signed({{2{ref_rd_ff[31]}}, ref_rd_ff}) + ts_term;
      upper34   = $signed({{2{upper_rd_ff[31]}}, upper_rd_ff});
      lower34   = $signed({{2{lower_rd_ff[31]}}, lower_rd_ff});
      if (ref_sum > upper34) begin
         ref_clamp = upper34;
      end else if (ref_sum < lower34) begin
         ref_clamp = lower34;
      end else begin
         ref_clamp = ref_sum;
      end

      err      = {ref_ff[31], ref_ff} - {meas_ff[31], meas_ff};
      err_mag  = err[32] ? (33'd0 - err) : err;
      diff     = {meas_ff[31], meas_ff} - {prev_rd_ff[31], prev_rd_ff};
      diff_mag = diff[32] ? (33'd0 - diff) : diff;

      p_mag = prod_ff[64:8];

      d_sum = {2'b00, prod_ff[47:0], 24'd0} + {18'd0, dlo_ff};
      d_mag = (d_sum > TERM_CAP) ? TERM_CAP : d_sum;

      total = $signed(p_term_ff) - (is_velocity ? 64'sd0 : $signed(d_term_ff));
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_fire) begin
               joint_idx_ff <= req_idx;
               joint_ff     <= req_joint;
               meas_ff      <= req_meas;
               rate_ff      <= req_rate;
            end
         end
         ST_READ: begin
            ref_rd_ff   <= ref_pos_ff[joint_idx_ff];
            prev_rd_ff  <= prev_pos_ff[joint_idx_ff];
            p_rd_ff     <= p_gain_ff[joint_idx_ff];
            d_rd_ff     <= d_gain_ff[joint_idx_ff];
            lower_rd_ff <= lower_ff[joint_idx_ff];
            upper_rd_ff <= upper_ff[joint_idx_ff];
         end
         ST_REF: begin
            ref_ff   <= ref_clamp[31:0];
            drive_ff <= {{16{ref_clamp[31]}}, ref_clamp[31:0]};
            sat_ff   <= 1'b0;
         end
         ST_MUL_P: begin
            err_neg_ff <= err[32];
         end
         ST_MUL_V: begin
            p_term_ff   <= err_neg_ff ? (64'd0 - {7'd0, p_mag}) : {7'd0, p_mag};
            diff_neg_ff <= diff[32];
         end
         ST_MUL_DLO: begin
            vel_hi_ff <= prod_ff[47:32];
         end
         ST_MUL_DHI: begin
            dlo_ff <= prod_ff[63:8];
         end
         ST_TERM_D: begin
            d_term_ff <= diff_neg_ff ? (64'd0 - d_mag[63:0]) : d_mag[63:0];
         end
         ST_DRIVE: begin
            if (total > DRIVE_MAX) begin
               drive_ff <= DRIVE_MAX48;
               sat_ff   <= 1'b1;
            end else if (total < DRIVE_MIN) begin
               drive_ff <= DRIVE_MIN48;
               sat_ff   <= 1'b1;
            end else begin
               drive_ff <= total[47:0];
               sat_ff   <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Joint tables: loads write from the request, a done tick writes back its reference.
   always_ff @(posedge clock) begin
      if (load_fire) begin
         ref_pos_ff[req_idx]  <= req_meas;
         prev_pos_ff[req_idx] <= req_meas;
         p_gain_ff[req_idx]   <= req_p;
         d_gain_ff[req_idx]   <= req_d;
         lower_ff[req_idx]    <= req_lower;
         upper_ff[req_idx]    <= req_upper;
      end else if (done_fire) begin
         ref_pos_ff[joint_idx_ff] <= ref_ff;
         if (!is_velocity && !is_position) begin
            prev_pos_ff[joint_idx_ff] <= meas_ff;
         end
      end
   end

   always_comb begin
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_joint_ff <= joint_ff;
         rsp_drive_ff <= drive_ff;
         rsp_ref_ff   <= ref_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ref_ff, rsp_drive_ff, rsp_joint_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

[rtl/jspd_checker.sv]
module jspd_checker
   import jspd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [REQ_TDATA_W-1:0]  req_tdata,
   input logic [0:0]              req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [0:0]              rsp_tuser
);

   logic req_in_range;

   assign req_in_range = 32'(req_tdata[3:0]) < 32'(JOINTS);

   // A waiting result holds its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A tick transaction occupies the block, so the request side closes next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_TICK) && req_in_range |=> !req_tready)
      else $error("request accepted during a tick");

   // A load completes in its own cycle and leaves the block ready.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOAD) |=> req_tready)
      else $error("block busy after a load");

   // The saturation flag only accompanies a drive at one of its limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[51:4] == DRIVE_MAX48) || (rsp_tdata[51:4] == DRIVE_MIN48))
      else $error("saturation flag with unsaturated drive");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind joint_setpoint_pd_servo jspd_checker u_checker (.*);
